@@ src/sha_pkg.sv @@
package sha_pkg;

   typedef enum logic [1:0] {
      CMD_BLOCK  = 2'd0,
      CMD_DIGEST = 2'd1
   } cmd_type;

   typedef struct packed {
      cmd_type      cmd;
      logic [511:0] block;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_ROUND = 2'd1,
      BK_FOLD  = 2'd2,
      BK_EMIT  = 2'd3
   } back_state_type;

   typedef enum logic [1:0] {
      FR_BYTES = 2'd0,
      FR_PAD   = 2'd1,
      FR_LEN   = 2'd2
   } front_state_type;

   localparam int QUEUE_DEPTH = 2;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
         32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
         32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
         32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
         32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
         32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[i];
   endfunction

   function automatic logic [31:0] initial_hash(input logic [2:0] i);
      logic [31:0] h [8];
      h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
            32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
      return h[i];
   endfunction

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ src/sha_front.sv @@
module sha_front import sha_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic [7:0] req_data_byte,
   input  logic     req_has_byte,
   input  logic     req_end_of_message,
   output logic     job_valid,
   input  logic     job_ready,
   output job_type  job
);

   logic [511:0]    buf_ff, buf_in;
   logic [63:0]     count_ff, count_in;
   logic [63:0]     len_ff, len_in;
   front_state_type state_ff, state_in;
   logic [5:0]      fill;

   assign fill = count_ff[8:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_BYTES;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      buf_ff <= buf_in;
      len_ff <= len_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      buf_in    = buf_ff;
      len_in    = len_ff;
      req_ready = 1'b0;
      job_valid = 1'b0;
      job.cmd   = CMD_BLOCK;
      job.block = buf_ff;
      case (state_ff)
         FR_BYTES: begin
            // a byte is taken only while the queue is ready, so a full buffer is queued at once
            req_ready = job_ready;
            if (req_valid && job_ready) begin
               if (req_has_byte) begin
                  buf_in[511 - 8 * fill -: 8] = req_data_byte;
                  count_in = count_ff + 64'd8;
                  if (fill == 6'd63) begin
                     job_valid = 1'b1;
                     job.block = buf_in;
                  end
               end
               if (req_end_of_message) begin
                  len_in   = count_in;
                  state_in = FR_PAD;
               end
            end
         end
         FR_PAD: begin
            buf_in[511 - 8 * count_ff[8:3] -: 8] = 8'h80;
            for (int i = 0; i < 64; i++)
               if (6'(i) > count_ff[8:3]) buf_in[511 - 8 * i -: 8] = 8'h00;
            if (count_ff[8:3] >= 6'd56) begin
               job_valid = 1'b1;
               job.block = buf_in;
               if (job_ready) begin
                  buf_in   = '0;
                  state_in = FR_LEN;
               end
            end else begin
               state_in = FR_LEN;
            end
         end
         FR_LEN: begin
            job_valid = 1'b1;
            job.cmd   = CMD_DIGEST;
            job.block = {buf_ff[511:64], len_ff};
            if (job_ready) begin
               count_in = '0;
               state_in = FR_BYTES;
            end
         end
         default: state_in = FR_BYTES;
      endcase
   end

endmodule

@@ src/sha_queue.sv @@
module sha_queue import sha_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   job_type    mem_ff [QUEUE_DEPTH];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != 2'd0;
   assign out_job   = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wr_ff] <= in_job;
   end

endmodule

@@ src/sha_core.sv @@
module sha_core import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  job_type     job,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   back_state_type state_ff, state_in;
   logic [31:0]    h_ff [8];
   logic [31:0]    v_ff [8];
   logic [31:0]    w_ff [16];
   logic [5:0]     rnd_ff;
   logic [2:0]     idx_ff;
   logic           digest_ff;
   logic [31:0]    t1, t2, s0, s1, wn;

   always_comb begin
      t1 = v_ff[7] + (ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_k(rnd_ff) + w_ff[0];
      t2 = (ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      s1 = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      s0 = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      wn = s1 + w_ff[9] + s0 + w_ff[0];
   end

   always_comb begin
      state_in  = state_ff;
      job_ready = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) state_in = BK_ROUND;
         end
         BK_ROUND: if (rnd_ff == 6'd63) state_in = BK_FOLD;
         BK_FOLD:  state_in = digest_ff ? BK_EMIT : BK_IDLE;
         BK_EMIT:  if (rsp_ready && idx_ff == 3'd7) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   assign rsp_valid       = state_ff == BK_EMIT;
   assign rsp_digest_word = h_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = idx_ff == 3'd7;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rnd_ff   <= '0;
         idx_ff   <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= initial_hash(3'(i));
      end else begin
         state_ff <= state_in;
         case (state_ff)
            BK_IDLE: begin
               rnd_ff <= '0;
               idx_ff <= '0;
            end
            BK_ROUND: rnd_ff <= rnd_ff + 6'd1;
            BK_FOLD: for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
            BK_EMIT: if (rsp_ready) begin
               idx_ff <= idx_ff + 3'd1;
               if (idx_ff == 3'd7)
                  for (int i = 0; i < 8; i++) h_ff[i] <= initial_hash(3'(i));
            end
            default: ;
         endcase
      end
      if (state_ff == BK_IDLE && job_valid) begin
         digest_ff <= job.cmd == CMD_DIGEST;
         for (int i = 0; i < 16; i++) w_ff[i] <= job.block[511 - 32 * i -: 32];
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (state_ff == BK_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= wn;
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
   end

endmodule

@@ src/sha256_stream_hasher.sv @@
// SHA-256 over a byte stream, at most one byte per item. Bytes gather at one per cycle
// while the queue has room, not while padding; each full 64-byte block is queued to a
// compression engine that runs one round per cycle, so long messages sustain about one
// byte per cycle while the two-entry queue absorbs the gap. On end_of_message the
// block is padded (one or two last blocks) and the digest leaves as eight 32-bit words,
// H0 first, last_word on the eighth; the hash state then resets for the next message.
module sha256_stream_hasher import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   logic    fq_valid, fq_ready, qc_valid, qc_ready;
   job_type fq_job, qc_job;

   sha_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data_byte, .req_has_byte,
      .req_end_of_message, .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job));

   sha_queue u_queue (
      .clock, .reset, .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
      .out_valid(qc_valid), .out_ready(qc_ready), .out_job(qc_job));

   sha_core u_core (
      .clock, .reset, .job_valid(qc_valid), .job_ready(qc_ready), .job(qc_job),
      .rsp_valid, .rsp_ready, .rsp_digest_word, .rsp_word_index, .rsp_last_word);

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last_word mismatch");
   a_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=> rsp_valid)
      else $error("digest words broken up");
   a_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=>
      rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("word index skipped");

endmodule
